// File: rtl/core/qte_pkg.sv
// Shared constants, types and the arctangent table for the quaternion to Euler angle unit.
// No dependencies; every other file in this folder imports it.
package qte_pkg;

	localparam int QW = 16;                // quaternion component width, Q1.15
	localparam int PW = 32;                // product of two components
	localparam int AW = 35;                // atan2 operand width
	localparam int SW = 32;                // clamped sine width
	localparam int SQW = 61;               // radicand width
	localparam int RW = 31;                // square root result width
	localparam int SQRT_STEPS = 31;        // one result bit per stage
	localparam int MW = 59;                // normalized magnitude width
	localparam int DW = 62;                // CORDIC x/y datapath width
	localparam int ZW = 34;                // angle accumulator, 2^-30 rad units
	localparam int KW = 31;                // degree conversion constant width
	localparam int CORDIC_ITER_DEF = 16;
	localparam int CORDIC_ITER_MAX = 24;
	localparam int FRONT_LAT = 3;
	localparam int CONV_LAT = 2;
	localparam int ATAN_PRE_LAT = 4;

	localparam logic signed [AW-1:0] ONE_Z = AW'(64'sd1073741824);
	localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sd1686629713);
	localparam logic signed [KW-1:0] RAD_TO_DEG_K = KW'(64'sd961263669);

	typedef struct packed {
		logic signed [AW-1:0] roll_y;
		logic signed [AW-1:0] roll_x;
		logic signed [AW-1:0] yaw_y;
		logic signed [AW-1:0] yaw_x;
		logic signed [SW-1:0] sine;
		logic                 clamped;
	} front_t;

	// atan(2^-i) in units of 2^-30 rad, truncated.
	function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
		logic signed [ZW-1:0] r;
		unique case (idx)
			5'd0:  r = ZW'(64'sd843314856);
			5'd1:  r = ZW'(64'sd497837829);
			5'd2:  r = ZW'(64'sd263043836);
			5'd3:  r = ZW'(64'sd133525158);
			5'd4:  r = ZW'(64'sd67021686);
			5'd5:  r = ZW'(64'sd33543515);
			5'd6:  r = ZW'(64'sd16775850);
			5'd7:  r = ZW'(64'sd8388437);
			5'd8:  r = ZW'(64'sd4194282);
			5'd9:  r = ZW'(64'sd2097149);
			5'd10: r = ZW'(64'sd1048575);
			5'd11: r = ZW'(64'sd524287);
			5'd12: r = ZW'(64'sd262143);
			5'd13: r = ZW'(64'sd131071);
			5'd14: r = ZW'(64'sd65535);
			5'd15: r = ZW'(64'sd32767);
			5'd16: r = ZW'(64'sd16383);
			5'd17: r = ZW'(64'sd8191);
			5'd18: r = ZW'(64'sd4095);
			5'd19: r = ZW'(64'sd2047);
			5'd20: r = ZW'(64'sd1023);
			5'd21: r = ZW'(64'sd511);
			5'd22: r = ZW'(64'sd255);
			5'd23: r = ZW'(64'sd127);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/quaternion_to_euler_angles_unit.sv
// Converts quaternions to roll, pitch and yaw (ZYX) in radians and degrees. The pipeline takes
// a new request every cycle while the output is not stalled; each result passes through three front
// stages, 31 square root stages (one root bit each), four CORDIC setup stages, one stage per
// CORDIC rotation and two output stages. A stall while a result waits on the output freezes the
// whole pipeline. Depends on qte_pkg, qte_front, qte_isqrt, qte_atan2 and qte_convert.
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [qte_pkg::QW-1:0] quat_w,
	input  logic signed [qte_pkg::QW-1:0] quat_x,
	input  logic signed [qte_pkg::QW-1:0] quat_y,
	input  logic signed [qte_pkg::QW-1:0] quat_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            roll_rad,
	output logic signed [14:0]            pitch_rad,
	output logic signed [15:0]            yaw_rad,
	output logic signed [15:0]            roll_deg,
	output logic signed [14:0]            pitch_deg,
	output logic signed [15:0]            yaw_deg,
	output logic                          pitch_clamped
);
	import qte_pkg::*;

	localparam int ITER = (CORDIC_ITERATIONS > CORDIC_ITER_MAX) ? CORDIC_ITER_MAX
		: CORDIC_ITERATIONS;
	localparam int TAIL = ATAN_PRE_LAT + ITER + CONV_LAT;
	localparam int LAT = FRONT_LAT + SQRT_STEPS + TAIL;

	logic en;
	logic [LAT-1:0] val_s;
	logic [TAIL-1:0] clamp_s;
	front_t ops_f, ops_r;
	logic [SQW-1:0] radicand;
	logic [RW-1:0] root;
	logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s <= '0;
		end else if (en) begin
			val_s <= {val_s[LAT-2:0], in_valid};
		end
	end
	assign out_valid = val_s[LAT-1];

	qte_front u_front (
		.clk(clk), .en(en),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.ops(ops_f), .radicand(radicand)
	);

	qte_isqrt #(.PASS_W($bits(front_t))) u_isqrt (
		.clk(clk), .en(en), .v_in(radicand), .pass_in(ops_f),
		.root(root), .pass_out(ops_r)
	);

	qte_atan2 #(.ITER(ITER)) u_roll (
		.clk(clk), .en(en), .y_in(ops_r.roll_y), .x_in(ops_r.roll_x), .z_out(z_roll)
	);

	qte_atan2 #(.ITER(ITER)) u_pitch (
		.clk(clk), .en(en), .y_in(AW'(ops_r.sine)), .x_in(AW'({1'b0, root})),
		.z_out(z_pitch)
	);

	qte_atan2 #(.ITER(ITER)) u_yaw (
		.clk(clk), .en(en), .y_in(ops_r.yaw_y), .x_in(ops_r.yaw_x), .z_out(z_yaw)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s <= {clamp_s[TAIL-2:0], ops_r.clamped};
		end
	end
	assign pitch_clamped = clamp_s[TAIL-1];

	qte_convert #(.OUT_W(16), .RAD_LIM(25736), .DEG_LIM(23040)) u_cv_roll (
		.clk(clk), .en(en), .z(z_roll), .rad(roll_rad), .deg(roll_deg)
	);

	qte_convert #(.OUT_W(15), .RAD_LIM(12868), .DEG_LIM(11520)) u_cv_pitch (
		.clk(clk), .en(en), .z(z_pitch), .rad(pitch_rad), .deg(pitch_deg)
	);

	qte_convert #(.OUT_W(16), .RAD_LIM(25736), .DEG_LIM(23040)) u_cv_yaw (
		.clk(clk), .en(en), .z(z_yaw), .rad(yaw_rad), .deg(yaw_deg)
	);

	// Both units come from the same angle, so a nonzero pair never disagrees in sign.
	a_roll_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_rad == 0 || roll_deg == 0 || roll_rad[15] == roll_deg[15]))
		else $error("roll radians and degrees disagree in sign");

	a_yaw_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_rad == 0 || yaw_deg == 0 || yaw_rad[15] == yaw_deg[15]))
		else $error("yaw radians and degrees disagree in sign");

	a_pitch_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_rad == 0 || pitch_deg == 0 || pitch_rad[14] == pitch_deg[14]))
		else $error("pitch radians and degrees disagree in sign");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(pitch_rad) <= 15'sd12868 && $signed(pitch_rad) >= -15'sd12868))
		else $error("pitch outside a quarter turn");

endmodule

// File: rtl/core/qte_front.sv
// Front end: component products, angle operands, sine clamp and the radicand 1 - s^2.
// Depends on qte_pkg. Three register stages.
module qte_front (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [qte_pkg::QW-1:0] quat_w,
	input  logic signed [qte_pkg::QW-1:0] quat_x,
	input  logic signed [qte_pkg::QW-1:0] quat_y,
	input  logic signed [qte_pkg::QW-1:0] quat_z,
	output qte_pkg::front_t               ops,
	output logic [qte_pkg::SQW-1:0]       radicand
);
	import qte_pkg::*;

	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] wx_s1, yz_s1, xy_s1, wz_s1, wy_s1, xz_s1;
	front_t ops_s2, ops_s3;
	logic [SQW-1:0] rad_s3;

	logic signed [AW-1:0] e_ww, e_xx, e_yy, e_zz, e_wx, e_yz, e_xy, e_wz, e_wy, e_xz;
	logic signed [AW-1:0] s_raw;
	front_t ops_n;
	logic signed [2*SW-1:0] ss;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= quat_w * quat_w;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xy_s1 <= quat_x * quat_y;
			wz_s1 <= quat_w * quat_z;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
		end
	end

	always_comb begin
		e_ww = AW'(ww_s1);
		e_xx = AW'(xx_s1);
		e_yy = AW'(yy_s1);
		e_zz = AW'(zz_s1);
		e_wx = AW'(wx_s1);
		e_yz = AW'(yz_s1);
		e_xy = AW'(xy_s1);
		e_wz = AW'(wz_s1);
		e_wy = AW'(wy_s1);
		e_xz = AW'(xz_s1);
		ops_n.roll_y = (e_wx + e_yz) <<< 1;
		ops_n.roll_x = e_ww - e_xx - e_yy + e_zz;
		ops_n.yaw_y  = (e_xy + e_wz) <<< 1;
		ops_n.yaw_x  = e_ww + e_xx - e_yy - e_zz;
		s_raw = (e_wy - e_xz) <<< 1;
		priority if (s_raw > ONE_Z) begin
			ops_n.sine = SW'(ONE_Z);
			ops_n.clamped = 1'b1;
		end else if (s_raw < -ONE_Z) begin
			ops_n.sine = SW'(-ONE_Z);
			ops_n.clamped = 1'b1;
		end else begin
			ops_n.sine = SW'(s_raw);
			ops_n.clamped = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ops_s2 <= ops_n;
		end
	end

	// The clamped sine is at most one, so its square fits the radicand width.
	assign ss = ops_s2.sine * ops_s2.sine;

	always_ff @(posedge clk) begin
		if (en) begin
			ops_s3 <= ops_s2;
			rad_s3 <= (SQW'(1) << (SQW - 1)) - ss[SQW-1:0];
		end
	end

	assign ops = ops_s3;
	assign radicand = rad_s3;

endmodule

// File: rtl/core/qte_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload delayed alongside.
// Depends on qte_pkg.
module qte_isqrt #(
	parameter int PASS_W = 1
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [qte_pkg::SQW-1:0]   v_in,
	input  logic [PASS_W-1:0]         pass_in,
	output logic [qte_pkg::RW-1:0]    root,
	output logic [PASS_W-1:0]         pass_out
);
	import qte_pkg::*;

	localparam int RESW = SQW + 1;

	logic [SQW-1:0]    v_s   [SQRT_STEPS+1];
	logic [RESW-1:0]   r_s   [SQRT_STEPS+1];
	logic [PASS_W-1:0] p_s   [SQRT_STEPS+1];

	assign v_s[0] = v_in;
	assign r_s[0] = '0;
	assign p_s[0] = pass_in;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [RESW-1:0] BIT = RESW'(1) << (SQW - 1 - 2 * j);
		logic [RESW-1:0] trial;
		assign trial = r_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[j+1] <= p_s[j];
				if (RESW'(v_s[j]) >= trial) begin
					v_s[j+1] <= v_s[j] - SQW'(trial);
					r_s[j+1] <= (r_s[j] >> 1) + BIT;
				end else begin
					v_s[j+1] <= v_s[j];
					r_s[j+1] <= r_s[j] >> 1;
				end
			end
		end
	end

	assign root = r_s[SQRT_STEPS][RW-1:0];
	assign pass_out = p_s[SQRT_STEPS];

endmodule

// File: rtl/core/qte_atan2.sv
// Pipelined vectoring CORDIC atan2: magnitude, normalization, quadrant pre-rotation,
// then one micro-rotation per stage. Depends on qte_pkg.
module qte_atan2 #(
	parameter int ITER = qte_pkg::CORDIC_ITER_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [qte_pkg::AW-1:0] y_in,
	input  logic signed [qte_pkg::AW-1:0] x_in,
	output logic signed [qte_pkg::ZW-1:0] z_out
);
	import qte_pkg::*;

	logic signed [DW-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [MW-1:0] m_s1, m_s2, m_s3;
	logic signed [DW-1:0] cx_s [ITER+1];
	logic signed [DW-1:0] cy_s [ITER+1];
	logic signed [ZW-1:0] cz_s [ITER+1];
	logic                 zero_s [ITER+1];

	logic [AW-1:0] ax, ay;
	logic signed [DW-1:0] xb, yb, xc, yc;
	logic [MW-1:0] mb, mc;

	always_comb begin
		ax = x_in[AW-1] ? AW'(-x_in) : AW'(x_in);
		ay = y_in[AW-1] ? AW'(-y_in) : AW'(y_in);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= DW'(x_in);
			y_s1 <= DW'(y_in);
			m_s1 <= (ax > ay) ? MW'(ax) : MW'(ay);
		end
	end

	// Greedy binary search for the shift that brings the magnitude into [2^58, 2^59).
	always_comb begin
		xb = x_s1;
		yb = y_s1;
		mb = m_s1;
		for (int k = 0; k < 3; k++) begin
			if (mb < (MW'(1) << (MW - (32 >> k)))) begin
				xb = xb <<< (32 >> k);
				yb = yb <<< (32 >> k);
				mb = mb << (32 >> k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= xb;
			y_s2 <= yb;
			m_s2 <= mb;
		end
	end

	always_comb begin
		xc = x_s2;
		yc = y_s2;
		mc = m_s2;
		for (int k = 0; k < 3; k++) begin
			if (mc < (MW'(1) << (MW - (4 >> k)))) begin
				xc = xc <<< (4 >> k);
				yc = yc <<< (4 >> k);
				mc = mc << (4 >> k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= xc;
			y_s3 <= yc;
			m_s3 <= mc;
		end
	end

	// Vectors in the left half plane are turned by a quarter turn first.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (m_s3 == '0);
			if (x_s3 < 0) begin
				if (y_s3 >= 0) begin
					cx_s[0] <= y_s3;
					cy_s[0] <= -x_s3;
					cz_s[0] <= HALF_PI_Z;
				end else begin
					cx_s[0] <= -y_s3;
					cy_s[0] <= x_s3;
					cz_s[0] <= -HALF_PI_Z;
				end
			end else begin
				cx_s[0] <= x_s3;
				cy_s[0] <= y_s3;
				cz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ANG = atan_tab(5'(i));
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ANG;
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ANG;
				end
			end
		end
	end

	assign z_out = zero_s[ITER] ? '0 : cz_s[ITER];

endmodule

// File: rtl/core/qte_convert.sv
// Angle output stage: radians Q2.13 and degrees Q8.7, rounded and clamped.
// Depends on qte_pkg. Two register stages.
module qte_convert #(
	parameter int OUT_W   = 16,
	parameter int RAD_LIM = 25736,
	parameter int DEG_LIM = 23040
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [qte_pkg::ZW-1:0] z,
	output logic signed [OUT_W-1:0]       rad,
	output logic signed [OUT_W-1:0]       deg
);
	import qte_pkg::*;

	localparam int PRW = ZW + KW;
	localparam logic signed [ZW-1:0] RAD_HI = ZW'(RAD_LIM);
	localparam logic signed [PRW-1:0] DEG_HI = PRW'(DEG_LIM);

	logic signed [OUT_W-1:0] rad_s1, rad_s2, deg_s2;
	logic signed [PRW-1:0] prod_s1;
	logic signed [ZW-1:0] r_full;
	logic signed [OUT_W-1:0] r_cl, d_cl;
	logic signed [PRW-1:0] d_full;

	always_comb begin
		r_full = (z + ZW'(1 << 16)) >>> 17;
		priority if (r_full > RAD_HI) r_cl = OUT_W'(RAD_HI);
		else if (r_full < -RAD_HI) r_cl = OUT_W'(-RAD_HI);
		else r_cl = OUT_W'(r_full);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= r_cl;
			prod_s1 <= PRW'(z) * PRW'(RAD_TO_DEG_K);
		end
	end

	always_comb begin
		d_full = (prod_s1 + (PRW'(1) <<< 46)) >>> 47;
		priority if (d_full > DEG_HI) d_cl = OUT_W'(DEG_HI);
		else if (d_full < -DEG_HI) d_cl = OUT_W'(-DEG_HI);
		else d_cl = OUT_W'(d_full);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2 <= rad_s1;
			deg_s2 <= d_cl;
		end
	end

	assign rad = rad_s2;
	assign deg = deg_s2;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for quaternion_to_euler_angles_unit: random and corner quaternions in,
// every result checked bit for bit against an in-bench fixed-point predictor. Depends on qte_pkg.
module tb_top;
	import qte_pkg::*;

	localparam int ITER = 16;
	localparam int LATENCY = 40 + ITER;
	localparam int N_RANDOM = 530;
	localparam int HANG_LIMIT = 4000;
	localparam int LONG_HOLD = 250;

	typedef struct {
		logic signed [15:0] roll_rad;
		logic signed [14:0] pitch_rad;
		logic signed [15:0] yaw_rad;
		logic signed [15:0] roll_deg;
		logic signed [14:0] pitch_deg;
		logic signed [15:0] yaw_deg;
		logic               pitch_clamped;
	} angles_t;

	class euler_scoreboard;
		angles_t expected_angles[$];
		int errors;

		// atan(2^-i) in 2^-30 rad units, truncated
		longint arctan_steps[24] = '{
			843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
			131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

		function new();
			errors = 0;
		endfunction

		function automatic longint round_down_shift(longint v, int n);
			return (v + (64'sd1 <<< (n - 1))) >>> n;
		endfunction

		function automatic longint limit_to(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		function automatic longint floor_sqrt(logic [63:0] v);
			logic [63:0] root, bitpos;
			root = 0;
			bitpos = 64'd1 << 62;
			while (bitpos > v)
				bitpos = bitpos >> 2;
			while (bitpos != 0) begin
				if (v >= root + bitpos) begin
					v = v - (root + bitpos);
					root = (root >> 1) + bitpos;
				end else begin
					root = root >> 1;
				end
				bitpos = bitpos >> 2;
			end
			return longint'(root);
		endfunction

		// Vectoring CORDIC on operands normalized to 2^58..2^59.
		function automatic longint arctan2(longint y, longint x);
			longint ax, ay, mag, angle, t, dx, dy;
			int k;
			ax = (x < 0) ? -x : x;
			ay = (y < 0) ? -y : y;
			mag = (ax > ay) ? ax : ay;
			k = 0;
			angle = 0;
			if (mag == 0)
				return 0;
			while (mag < (64'sd1 <<< 58)) begin
				mag = mag <<< 1;
				k++;
			end
			x = x * (64'sd1 <<< k);
			y = y * (64'sd1 <<< k);
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; angle = longint'(HALF_PI_Z);
				end else begin
					x = -y; y = t; angle = -longint'(HALF_PI_Z);
				end
			end
			for (int i = 0; i < ITER && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; angle += arctan_steps[i];
				end else begin
					x -= dx; y += dy; angle -= arctan_steps[i];
				end
			end
			return angle;
		endfunction

		function automatic angles_t euler_from_quat(longint w, longint x, longint y, longint z);
			angles_t a;
			longint roll_y, roll_x, yaw_y, yaw_x, s, c, zr, zp, zy;
			longint one_z;
			one_z = 64'sd1 <<< 30;
			roll_y = 2 * (w * x + y * z);
			roll_x = w * w - x * x - y * y + z * z;
			yaw_y = 2 * (x * y + w * z);
			yaw_x = w * w + x * x - y * y - z * z;
			s = 2 * (w * y - x * z);
			a.pitch_clamped = 1'b0;
			if (s > one_z) begin
				s = one_z; a.pitch_clamped = 1'b1;
			end
			if (s < -one_z) begin
				s = -one_z; a.pitch_clamped = 1'b1;
			end
			c = floor_sqrt((64'd1 << 60) - 64'(s * s));
			zr = arctan2(roll_y, roll_x);
			zp = arctan2(s, c);
			zy = arctan2(yaw_y, yaw_x);
			a.roll_rad = 16'(limit_to(round_down_shift(zr, 17), 25736));
			a.pitch_rad = 15'(limit_to(round_down_shift(zp, 17), 12868));
			a.yaw_rad = 16'(limit_to(round_down_shift(zy, 17), 25736));
			a.roll_deg = 16'(limit_to(round_down_shift(zr * longint'(RAD_TO_DEG_K), 47), 23040));
			a.pitch_deg = 15'(limit_to(round_down_shift(zp * longint'(RAD_TO_DEG_K), 47), 11520));
			a.yaw_deg = 16'(limit_to(round_down_shift(zy * longint'(RAD_TO_DEG_K), 47), 23040));
			return a;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void note_request(logic signed [15:0] w, logic signed [15:0] x,
				logic signed [15:0] y, logic signed [15:0] z);
			expected_angles.push_back(euler_from_quat(w, x, y, z));
		endfunction

		task check_result(angles_t got);
			angles_t e;
			if (expected_angles.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			e = expected_angles.pop_front();
			if (got.roll_rad !== e.roll_rad)
				report($sformatf("roll_rad %0d, want %0d", got.roll_rad, e.roll_rad));
			if (got.pitch_rad !== e.pitch_rad)
				report($sformatf("pitch_rad %0d, want %0d", got.pitch_rad, e.pitch_rad));
			if (got.yaw_rad !== e.yaw_rad)
				report($sformatf("yaw_rad %0d, want %0d", got.yaw_rad, e.yaw_rad));
			if (got.roll_deg !== e.roll_deg)
				report($sformatf("roll_deg %0d, want %0d", got.roll_deg, e.roll_deg));
			if (got.pitch_deg !== e.pitch_deg)
				report($sformatf("pitch_deg %0d, want %0d", got.pitch_deg, e.pitch_deg));
			if (got.yaw_deg !== e.yaw_deg)
				report($sformatf("yaw_deg %0d, want %0d", got.yaw_deg, e.yaw_deg));
			if (got.pitch_clamped !== e.pitch_clamped)
				report($sformatf("pitch_clamped %0b, want %0b", got.pitch_clamped,
					e.pitch_clamped));
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic signed [15:0] roll_rad, yaw_rad, roll_deg, yaw_deg;
	logic signed [14:0] pitch_rad, pitch_deg;
	logic pitch_clamped;

	euler_scoreboard sb = new();
	int results_seen = 0;
	int idle_cycles = 0;
	bit long_hold_done = 0;

	quaternion_to_euler_angles_unit #(.CORDIC_ITERATIONS(ITER)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.roll_rad(roll_rad), .pitch_rad(pitch_rad), .yaw_rad(yaw_rad),
		.roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
		.pitch_clamped(pitch_clamped)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Offers one request and holds it until the block takes it.
	task send_request(logic signed [15:0] w, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		quat_w <= w;
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(w, x, y, z);
	endtask

	task idle_for(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] random_component(int kind);
		case (kind)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 64)) - 32);
			2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : -16'sh8000;
			default: return 16'($signed($urandom_range(0, 46340)) - 23170);
		endcase
	endfunction

	initial begin
		int burst;
		int kind;
		bit drained;
		drained = 1'b0;
		in_valid = 1'b0;
		quat_w = '0;
		quat_x = '0;
		quat_y = '0;
		quat_z = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners: zero vector, identity, full-scale signs, gimbal lock and clamped pitch,
		// and vectors in the left half plane of the arctangent.
		send_request(0, 0, 0, 0);
		send_request(16'sh7fff, 0, 0, 0);
		send_request(-16'sh8000, 0, 0, 0);
		send_request(0, 16'sh7fff, 0, 0);
		send_request(0, 0, 16'sh7fff, 0);
		send_request(0, 0, 0, 16'sh7fff);
		send_request(0, 0, 0, -16'sh8000);
		send_request(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
		send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_request(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
		send_request(23170, 0, 23170, 0);
		send_request(23170, 0, -23170, 0);
		send_request(23170, 1, 23170, 0);
		send_request(16'sh7fff, 0, 16'sh7fff, 0);
		send_request(16'sh7fff, 0, -16'sh8000, 0);
		send_request(0, 16'sh7fff, 0, 16'sh7fff);
		send_request(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
		send_request(1, 0, 0, 0);
		send_request(0, -1, 0, 0);
		send_request(-1, -1, 1, 1);
		idle_for(3);

		for (int n = 0; n < N_RANDOM; ) begin
			if (n >= 350 && !drained) begin
				// Let the pipeline drain completely once.
				drained = 1'b1;
				in_valid <= 1'b0;
				while (sb.expected_angles.size() != 0)
					@(posedge clk);
			end
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
				kind = $urandom_range(0, 9);
				if (kind > 3)
					kind = 0;
				send_request(random_component(kind), random_component(kind),
					random_component(kind), random_component(kind));
			end
			idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
		end
		in_valid <= 1'b0;

		while (sb.expected_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0)
			$display("quaternion_to_euler_angles_unit verification clean");
		else
			$display("quaternion_to_euler_angles_unit verification failed");
		$finish;
	end

	// Result side: stall pattern changes mode after each random span, with one long hold-off.
	initial begin
		int mode;
		int span;
		angles_t got;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			while (span > 0) begin
				@(posedge clk);
				if (out_valid && !out_stall) begin
					got.roll_rad = roll_rad;
					got.pitch_rad = pitch_rad;
					got.yaw_rad = yaw_rad;
					got.roll_deg = roll_deg;
					got.pitch_deg = pitch_deg;
					got.yaw_deg = yaw_deg;
					got.pitch_clamped = pitch_clamped;
					sb.check_result(got);
					results_seen++;
				end
				if (!long_hold_done && results_seen >= 120) begin
					long_hold_done = 1;
					mode = 4;
					span = LONG_HOLD;
				end
				case (mode)
					0, 1: out_stall <= 1'b0;
					2: out_stall <= ($urandom_range(0, 3) == 0);
					3: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= 1'b1;
				endcase
				span--;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("quaternion_to_euler_angles_unit verification failed");
			$finish;
		end
	end

endmodule

// File: sim.f
rtl/core/qte_pkg.sv
rtl/core/qte_front.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_atan2.sv
rtl/core/qte_convert.sv
rtl/core/quaternion_to_euler_angles_unit.sv
verif/tb_top.sv
